FILE: sv/u2u8_pkg.sv
package u2u8_pkg;

   localparam int UnitWidth = 16;
   localparam int CpWidth   = 21;
   localparam int ByteWidth = 8;
   localparam int MaxBytes  = 4;
   localparam int IdxWidth  = $clog2(MaxBytes);

   typedef logic [UnitWidth-1:0] unit_type;
   typedef logic [CpWidth-1:0]   cp_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [IdxWidth-1:0]  idx_type;

   // Lead byte markers and continuation marker
   localparam byte_type Lead2Mark = 8'hC0;
   localparam byte_type Lead3Mark = 8'hE0;
   localparam byte_type Lead4Mark = 8'hF0;
   localparam byte_type ContMark  = 8'h80;
   localparam byte_type Terminator = 8'h00;

   localparam cp_type SupplementaryBase = 21'h10000;

   // Byte sequence for one code point: bytes in send order, index of final byte
   typedef struct packed {
      byte_type [MaxBytes-1:0] bytes;
      idx_type                 last_idx;
   } burst_type;

   // Unit falls in the surrogate range 0xD800..0xDFFF
   function automatic logic is_surrogate(input unit_type u);
      return u[15:11] == 5'b11011;
   endfunction

   // UTF-8 encode a code point below 0x200000
   function automatic burst_type encode_cp(input cp_type cp);
      burst_type b;
      b = '0;
      if (cp[20:7] == '0) begin
         b.bytes[0] = {1'b0, cp[6:0]};
         b.last_idx = idx_type'(0);
      end else if (cp[20:11] == '0) begin
         b.bytes[0] = Lead2Mark | {3'b000, cp[10:6]};
         b.bytes[1] = ContMark | {2'b00, cp[5:0]};
         b.last_idx = idx_type'(1);
      end else if (cp[20:16] == '0) begin
         b.bytes[0] = Lead3Mark | {4'b0000, cp[15:12]};
         b.bytes[1] = ContMark | {2'b00, cp[11:6]};
         b.bytes[2] = ContMark | {2'b00, cp[5:0]};
         b.last_idx = idx_type'(2);
      end else begin
         b.bytes[0] = Lead4Mark | {5'b00000, cp[20:18]};
         b.bytes[1] = ContMark | {2'b00, cp[17:12]};
         b.bytes[2] = ContMark | {2'b00, cp[11:6]};
         b.bytes[3] = ContMark | {2'b00, cp[5:0]};
         b.last_idx = idx_type'(3);
      end
      return b;
   endfunction

endpackage

FILE: sv/u2u8_req_if.sv
interface u2u8_req_if;
   logic                valid;
   logic                ready;
   u2u8_pkg::unit_type  code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

FILE: sv/u2u8_rsp_if.sv
interface u2u8_rsp_if;
   logic                valid;
   logic                ready;
   u2u8_pkg::byte_type  utf8_byte;
   logic                last_of_char;
   logic                end_of_string;

   modport source (output valid, output utf8_byte, output last_of_char,
                   output end_of_string, input ready);
   modport sink   (input valid, input utf8_byte, input last_of_char,
                   input end_of_string, output ready);
endinterface

FILE: sv/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Each req transaction carries one 16-bit code unit;
// each rsp transaction carries one UTF-8 byte, with last_of_char set on the final
// byte caused by that unit and end_of_string set on the 0x00 terminator sent for
// a zero unit. A surrogate unit is held and sends nothing; the next nonzero unit is
// joined with it into a 4-byte sequence, and a zero unit flushes a held unit as 3
// bytes before the terminator. A unit passes through an input register and is
// encoded into a 4-byte output buffer; the buffer drains one byte per cycle while
// rsp.ready is high. A unit yields 1 to 4 bytes (a held surrogate sends nothing),
// and the input side keeps accepting while the buffer drains its last byte.
module utf16_to_utf8_transcoder (
   input logic              clock,
   input logic              reset,
   u2u8_req_if.sink         req,
   u2u8_rsp_if.source       rsp
);

   // Input register
   logic                  in_valid_ff, in_valid_in;
   u2u8_pkg::unit_type    unit_ff, unit_in;

   // Held surrogate
   logic                  pend_valid_ff, pend_valid_in;
   u2u8_pkg::unit_type    pend_unit_ff, pend_unit_in;

   // Output byte buffer
   logic                  buf_valid_ff, buf_valid_in;
   u2u8_pkg::burst_type   burst_ff, burst_in;
   logic                  eos_ff, eos_in;
   u2u8_pkg::idx_type     idx_ff, idx_in;

   // Encode results for the registered unit
   u2u8_pkg::burst_type   enc_burst;
   logic                  enc_eos;
   logic                  enc_emits;
   u2u8_pkg::cp_type      pair_cp;

   logic                  rsp_take;
   logic                  buf_done;
   logic                  buf_free;
   logic                  advance;
   logic                  req_take;

   // Encode the unit against the held surrogate
   always_comb begin
      pair_cp = u2u8_pkg::cp_type'({pend_unit_ff[9:0], unit_ff[9:0]})
              + u2u8_pkg::SupplementaryBase;
      enc_burst     = u2u8_pkg::encode_cp(u2u8_pkg::cp_type'(unit_ff));
      enc_eos       = 1'b0;
      enc_emits     = 1'b1;
      pend_valid_in = pend_valid_ff;
      pend_unit_in  = pend_unit_ff;
      if (pend_valid_ff) begin
         pend_valid_in = 1'b0;
         pend_unit_in  = '0;
         if (unit_ff == '0) begin
            // flush the lone surrogate as three bytes, then terminate
            enc_burst          = u2u8_pkg::encode_cp(u2u8_pkg::cp_type'(pend_unit_ff));
            enc_burst.bytes[3] = u2u8_pkg::Terminator;
            enc_burst.last_idx = u2u8_pkg::idx_type'(3);
            enc_eos            = 1'b1;
         end else begin
            enc_burst = u2u8_pkg::encode_cp(pair_cp);
         end
      end else if (unit_ff == '0) begin
         enc_burst          = '0;
         enc_burst.bytes[0] = u2u8_pkg::Terminator;
         enc_burst.last_idx = u2u8_pkg::idx_type'(0);
         enc_eos            = 1'b1;
      end else if (u2u8_pkg::is_surrogate(unit_ff)) begin
         // hold the surrogate, send nothing
         enc_emits     = 1'b0;
         pend_valid_in = 1'b1;
         pend_unit_in  = unit_ff;
      end
   end

   // Handshake and flow control
   assign rsp_take  = rsp.valid && rsp.ready;
   assign buf_done  = rsp_take && (idx_ff == burst_ff.last_idx);
   assign buf_free  = !buf_valid_ff || buf_done;
   assign advance   = in_valid_ff && (!enc_emits || buf_free);
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   // Next input register
   always_comb begin
      in_valid_in = in_valid_ff;
      unit_in     = unit_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         unit_in     = req.code_unit;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Next buffer: load on an advance that emits, step the index on each taken byte
   always_comb begin
      buf_valid_in = buf_valid_ff;
      burst_in     = burst_ff;
      eos_in       = eos_ff;
      idx_in       = idx_ff;
      if (advance && enc_emits) begin
         buf_valid_in = 1'b1;
         burst_in     = enc_burst;
         eos_in       = enc_eos;
         idx_in       = '0;
      end else if (buf_done) begin
         buf_valid_in = 1'b0;
      end else if (rsp_take) begin
         idx_in = idx_ff + u2u8_pkg::idx_type'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_unit_ff  <= '0;
         buf_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         if (advance) begin
            pend_valid_ff <= pend_valid_in;
            pend_unit_ff  <= pend_unit_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      unit_ff  <= unit_in;
      burst_ff <= burst_in;
      eos_ff   <= eos_in;
   end

   // Drive the result channel from the buffer
   assign rsp.valid         = buf_valid_ff;
   assign rsp.utf8_byte     = burst_ff.bytes[idx_ff];
   assign rsp.last_of_char  = (idx_ff == burst_ff.last_idx);
   assign rsp.end_of_string = eos_ff && (idx_ff == burst_ff.last_idx);

endmodule

FILE: tb/sv/tb_utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder;

   localparam u2u8_pkg::unit_type SurrogateFirst = 16'hD800;
   localparam u2u8_pkg::unit_type SurrogateLast  = 16'hDFFF;
   localparam u2u8_pkg::unit_type EndOfString    = 16'h0000;

   // One expected UTF-8 output transaction
   typedef struct {
      u2u8_pkg::byte_type data;
      logic               last;
      logic               eos;
   } utf8_byte_type;

   logic clock;
   logic reset;

   u2u8_req_if req_ch ();
   u2u8_rsp_if rsp_ch ();

   utf16_to_utf8_transcoder uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Code units waiting to be sent, with a flag to drain the block first
   u2u8_pkg::unit_type unit_queue[$];
   bit                 drain_queue[$];
   bit                 mark_drain;

   // Expected bytes and the predictor's copy of the block state
   utf8_byte_type      expected_bytes[$];
   u2u8_pkg::unit_type held_unit;
   logic               held_valid;

   int units_sent;
   int total_units;
   int bytes_checked;
   int terminators;
   int pairs_joined;
   int lone_flushed;
   int mismatches;
   int send_gap;
   int stall_left;
   int hold_left;
   bit long_hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Keep both sides busy over a window, otherwise mostly short gaps
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (units_sent >= 100 && units_sent < 180) return 0;
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void queue_unit(u2u8_pkg::unit_type u);
      unit_queue.push_back(u);
      drain_queue.push_back(mark_drain);
      mark_drain = 1'b0;
   endfunction

   function automatic void push_byte(u2u8_pkg::byte_type d, logic eos);
      utf8_byte_type b;
      b.data = d;
      b.last = 1'b0;
      b.eos  = eos;
      expected_bytes.push_back(b);
   endfunction

   function automatic void encode_code_point(u2u8_pkg::cp_type cp);
      if (cp < 21'h80) begin
         push_byte(u2u8_pkg::byte_type'(cp), 1'b0);
      end else if (cp < 21'h800) begin
         push_byte(u2u8_pkg::Lead2Mark | u2u8_pkg::byte_type'(cp >> 6), 1'b0);
         push_byte(u2u8_pkg::ContMark | u2u8_pkg::byte_type'(cp & 21'h3F), 1'b0);
      end else if (cp < 21'h10000) begin
         push_byte(u2u8_pkg::Lead3Mark | u2u8_pkg::byte_type'(cp >> 12), 1'b0);
         push_byte(u2u8_pkg::ContMark | u2u8_pkg::byte_type'((cp >> 6) & 21'h3F), 1'b0);
         push_byte(u2u8_pkg::ContMark | u2u8_pkg::byte_type'(cp & 21'h3F), 1'b0);
      end else begin
         push_byte(u2u8_pkg::Lead4Mark | u2u8_pkg::byte_type'((cp >> 18) & 21'h7), 1'b0);
         push_byte(u2u8_pkg::ContMark | u2u8_pkg::byte_type'((cp >> 12) & 21'h3F), 1'b0);
         push_byte(u2u8_pkg::ContMark | u2u8_pkg::byte_type'((cp >> 6) & 21'h3F), 1'b0);
         push_byte(u2u8_pkg::ContMark | u2u8_pkg::byte_type'(cp & 21'h3F), 1'b0);
      end
   endfunction

   // Work out the bytes one accepted code unit produces
   function automatic void predict_unit(u2u8_pkg::unit_type u);
      int               first;
      u2u8_pkg::cp_type cp;
      utf8_byte_type    tail;
      first = expected_bytes.size();
      if (held_valid) begin
         if (u == EndOfString) begin
            encode_code_point(u2u8_pkg::cp_type'(held_unit));
            push_byte(u2u8_pkg::Terminator, 1'b1);
            lone_flushed++;
         end else begin
            cp = ((u2u8_pkg::cp_type'(held_unit[9:0]) << 10)
                  | u2u8_pkg::cp_type'(u[9:0])) + u2u8_pkg::SupplementaryBase;
            encode_code_point(cp);
            pairs_joined++;
         end
         held_valid = 1'b0;
         held_unit  = '0;
      end else if (u == EndOfString) begin
         push_byte(u2u8_pkg::Terminator, 1'b1);
      end else if (u >= SurrogateFirst && u <= SurrogateLast) begin
         held_unit  = u;
         held_valid = 1'b1;
      end else begin
         encode_code_point(u2u8_pkg::cp_type'(u));
      end
      // Flag the final byte of this unit
      if (expected_bytes.size() > first) begin
         tail = expected_bytes.pop_back();
         tail.last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   task automatic check_byte(u2u8_pkg::byte_type d, logic last, logic eos);
      utf8_byte_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("unexpected byte %02h", d));
      end else begin
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (eos === 1'b1) terminators++;
         if (d !== want.data)
            report_mismatch($sformatf("utf8_byte %02h, expected %02h", d, want.data));
         if (last !== want.last)
            report_mismatch($sformatf("last_of_char %b, expected %b (byte %02h)",
                                      last, want.last, want.data));
         if (eos !== want.eos)
            report_mismatch($sformatf("end_of_string %b, expected %b (byte %02h)",
                                      eos, want.eos, want.data));
      end
   endtask

   // Driver: predict on each accepted transaction, then offer the next unit
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_unit(req_ch.code_unit);
            units_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (unit_queue.size() > 0 &&
                         (drain_queue[0] == 1'b0 || expected_bytes.size() == 0)) begin
               req_ch.valid     <= 1'b1;
               req_ch.code_unit <= unit_queue.pop_front();
               void'(drain_queue.pop_front());
               send_gap = pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted byte, then choose ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_byte(rsp_ch.utf8_byte, rsp_ch.last_of_char, rsp_ch.end_of_string);
         // Hold off once for a long stretch so the input side backs up
         if (!long_hold_done && units_sent >= 110) begin
            long_hold_done = 1'b1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_utf16_to_utf8_transcoder failed");
      $finish;
   end

   initial begin
      u2u8_pkg::unit_type u;
      int                 str_len;
      int                 pick;
      int                 string_idx;

      req_ch.valid     = 1'b0;
      req_ch.code_unit = '0;
      rsp_ch.ready     = 1'b0;
      held_unit        = '0;
      held_valid       = 1'b0;
      mark_drain       = 1'b0;
      units_sent       = 0;
      bytes_checked    = 0;
      terminators      = 0;
      pairs_joined     = 0;
      lone_flushed     = 0;
      mismatches       = 0;
      long_hold_done   = 1'b0;
      reset            = 1'b1;

      // Directed: size boundaries, bit patterns, every surrogate case
      queue_unit(16'h0000);
      queue_unit(16'h0001); queue_unit(16'h007F); queue_unit(16'h0080);
      queue_unit(16'h07FF); queue_unit(16'h0800); queue_unit(16'hD7FF);
      queue_unit(16'hE000); queue_unit(16'hFFFF); queue_unit(16'hAAAA);
      queue_unit(16'h5555);
      queue_unit(16'hD800); queue_unit(16'hDC00);
      queue_unit(16'hDBFF); queue_unit(16'hDFFF);
      queue_unit(16'hDC00); queue_unit(16'h0041);
      queue_unit(16'hD800); queue_unit(16'hD800);
      queue_unit(16'hD800); queue_unit(16'hFFFF);
      queue_unit(16'hDFFF); queue_unit(16'h0000);
      queue_unit(16'hD800); queue_unit(16'h0000);

      // Random strings: mostly well-formed, some noise, each ended by a zero
      string_idx = 0;
      while (unit_queue.size() < 425) begin
         mark_drain = (string_idx % 6 == 0) &&
                      (unit_queue.size() < 90 || unit_queue.size() > 220);
         str_len = $urandom_range(1, 10);
         for (int c = 0; c < str_len; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               u = u2u8_pkg::unit_type'($urandom_range(16'h0001, 16'h007F));
            end else if (pick < 45) begin
               u = u2u8_pkg::unit_type'($urandom_range(16'h0080, 16'h07FF));
            end else if (pick < 70) begin
               if ($urandom_range(0, 1) == 0)
                  u = u2u8_pkg::unit_type'($urandom_range(16'h0800, 16'hD7FF));
               else
                  u = u2u8_pkg::unit_type'($urandom_range(16'hE000, 16'hFFFF));
            end else if (pick < 92) begin
               queue_unit(u2u8_pkg::unit_type'($urandom_range(16'hD800, 16'hDBFF)));
               u = u2u8_pkg::unit_type'($urandom_range(16'hDC00, 16'hDFFF));
            end else begin
               case ($urandom_range(0, 2))
                  0: u = u2u8_pkg::unit_type'($urandom_range(SurrogateFirst, SurrogateLast));
                  1: u = u2u8_pkg::unit_type'($urandom);
                  default: u = EndOfString;
               endcase
            end
            queue_unit(u);
         end
         queue_unit(EndOfString);
         string_idx++;
      end
      total_units = unit_queue.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transaction, then for the bytes still owed
      while (units_sent != total_units) @(posedge clock);
      for (int w = 0; w < 2000 && expected_bytes.size() != 0; w++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never arrived",
                                   expected_bytes.size()));

      $display("Sent %0d code units in %0d strings; checked %0d bytes, %0d terminators.",
               units_sent, string_idx, bytes_checked, terminators);
      $display("Joined %0d surrogate pairs, flushed %0d lone surrogates; %0d mismatches.",
               pairs_joined, lone_flushed, mismatches);
      if (mismatches == 0) begin
         $display("tb_utf16_to_utf8_transcoder passed");
      end else begin
         $display("tb_utf16_to_utf8_transcoder failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/u2u8_pkg.sv
sv/u2u8_req_if.sv
sv/u2u8_rsp_if.sv
sv/utf16_to_utf8_transcoder.sv
tb/sv/tb_utf16_to_utf8_transcoder.sv
